[src/cch_pkg.sv]
// Package for the calibrated compass heading block.
// Holds field widths, fixed-point formats, status and state codes, and the CORDIC angle table.
// No dependencies; every other file in src imports it.
package cch_pkg;

  // Fixed widths of the request and result fields.
  localparam int SAMPLE_W  = 16;
  localparam int HEADING_W = 9;
  localparam int STATUS_W  = 2;

  // Fixed-point formats: scaled samples are Q2.16 and angles are Q11.16 degrees.
  localparam int FRAC_W = 16;
  localparam int QUO_W  = 17;               // magnitude of a scaled sample, at most 1.0
  localparam int FX_W   = QUO_W + 1;        // signed scaled sample
  localparam int XY_W   = 20;               // CORDIC vector, with room for the gain
  localparam int ANG_W  = 27;               // signed angle accumulator
  localparam int DEG_W  = ANG_W - FRAC_W;   // signed whole degrees

  // Quotient bits are produced one per cycle.
  localparam int DIV_CNT_W = 5;

  localparam int ANGLE_TABLE_LEN = 24;
  localparam int ANGLE_IDX_W     = 5;

  localparam logic signed [ANG_W-1:0] DEG_90  = ANG_W'(90 * 65536);
  localparam logic signed [ANG_W-1:0] DEG_180 = ANG_W'(180 * 65536);
  localparam logic signed [DEG_W-1:0] DEG_FULL_TURN = DEG_W'(360);

  // atan(2^-i) in degrees, Q11.16, rounded to nearest.
  localparam logic signed [ANG_W-1:0] ATAN_TABLE [ANGLE_TABLE_LEN] = '{
    27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
    27'sd234379,  27'sd117305,  27'sd58666,  27'sd29335,
    27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
    27'sd917,     27'sd458,     27'sd229,    27'sd115,
    27'sd57,      27'sd29,      27'sd14,     27'sd7,
    27'sd4,       27'sd2,       27'sd1,      27'sd0
  };

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW       = 2'd0,
    ST_SPAN_ZERO = 2'd1,
    ST_HELD      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_X,
    S_DIV_Y,
    S_CORDIC,
    S_EMIT
  } state_e;

endpackage

[src/cch_if.sv]
// Valid/ready channel interfaces for the compass heading block.
// Depends on cch_pkg for the field widths.
interface cch_in_if import cch_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       read_ok;
  logic signed [SAMPLE_W-1:0] x_sample;
  logic signed [SAMPLE_W-1:0] y_sample;

  modport source (output valid, read_ok, x_sample, y_sample, input ready);
  modport sink   (input valid, read_ok, x_sample, y_sample, output ready);
endinterface

interface cch_out_if import cch_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [HEADING_W-1:0] heading_deg;
  logic [STATUS_W-1:0]  status;

  modport source (output valid, heading_deg, status, input ready);
  modport sink   (input valid, heading_deg, status, output ready);
endinterface

[src/cch_div.sv]
// Restoring divider that scales a centered sample by its span into signed Q2.16.
// One quotient bit per cycle. Depends on cch_pkg.
module cch_div import cch_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   neg_i,
  input  logic [SAMPLE_WIDTH:0]  mag_i,
  input  logic [SAMPLE_WIDTH:0]  den_i,
  output logic                   done_o,
  output logic signed [FX_W-1:0] quo_o
);

  localparam int SW = SAMPLE_WIDTH;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [SW:0]          rem_q, den_q;
  logic [QUO_W-1:0]     shr_q, quo_q;
  logic                 neg_q;
  logic [SW+1:0]        trial, diff;
  logic                 ge;

  // One trial subtraction per cycle.
  always_comb begin
    trial = {rem_q, shr_q[QUO_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
  end

  // Control: busy flag, step count and done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(QUO_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath. The dividend is mag * 2^16; its top bits start as the remainder,
  // which is already below the divisor because the quotient fits in QUO_W bits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, mag_i[SW:1]};
      shr_q <= {mag_i[0], {(QUO_W-1){1'b0}}};
      quo_q <= '0;
      den_q <= den_i;
      neg_q <= neg_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[SW:0] : trial[SW:0];
      shr_q <= {shr_q[QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

[src/cch_cordic.sv]
// Vectoring CORDIC that returns atan2(y, x) in Q11.16 degrees, range (-180, 180].
// One micro-rotation per cycle; axis vectors finish at once. Depends on cch_pkg.
module cch_cordic import cch_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [FX_W-1:0]  fx_i,
  input  logic signed [FX_W-1:0]  fy_i,
  output logic                    done_o,
  output logic signed [ANG_W-1:0] angle_o
);

  localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  logic                    busy_q, done_q;
  logic [CNT_W-1:0]        step_q;
  logic signed [XY_W-1:0]  x_q, y_q, xs, ys;
  logic signed [ANG_W-1:0] z_q, ang;
  logic signed [XY_W-1:0]  fx_ext, fy_ext;
  logic                    on_axis;

  assign fx_ext  = XY_W'(fx_i);
  assign fy_ext  = XY_W'(fy_i);
  assign on_axis = (fy_i == '0) || (fx_i == '0);

  // Arithmetic shifts floor, as the rotation needs.
  always_comb begin
    xs  = x_q >>> step_q;
    ys  = y_q >>> step_q;
    ang = ATAN_TABLE[ANGLE_IDX_W'(step_q)];
  end

  // Control: step counter and done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        step_q <= '0;
        busy_q <= !on_axis;
        done_q <= on_axis;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == CNT_W'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Vector and angle. Axis vectors get exact angles; the left half plane is
  // turned by a quarter first, with that quarter preloaded.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= fx_ext;
      y_q <= fy_ext;
      z_q <= '0;
      if (fy_i == '0) begin
        z_q <= fx_i[FX_W-1] ? DEG_180 : '0;
      end else if (fx_i == '0) begin
        z_q <= fy_i[FX_W-1] ? -DEG_90 : DEG_90;
      end else if (fx_i[FX_W-1]) begin
        if (!fy_i[FX_W-1]) begin
          x_q <= fy_ext;
          y_q <= -fx_ext;
          z_q <= DEG_90;
        end else begin
          x_q <= -fy_ext;
          y_q <= fx_ext;
          z_q <= -DEG_90;
        end
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + ang;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - ang;
      end
    end
  end

  assign done_o  = done_q;
  assign angle_o = z_q;

endmodule

[src/calibrated_compass_heading.sv]
// Calibrated compass heading: min/max calibration, span scaling and CORDIC atan2.
// Sequence: a failed read goes straight to the emit state, and a zero span is found in the
// check state; a calibrated sample is divided for X then Y by the one shared bit-serial
// divider and then passes through the one CORDIC rotator before the emit state.
// Throughput: one request at a time; ready is low until the result is in the output register.
// Reset clears the bounds, the last heading, the sequencer and the output valid flag.
module calibrated_compass_heading import cch_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  cch_in_if.sink   in_i,
  cch_out_if.source out_o
);

  localparam int SW = SAMPLE_WIDTH;

  state_e state_q, state_d;

  logic signed [SW-1:0]    x_s_q, y_s_q;
  logic signed [SW-1:0]    x_min_q, x_max_q, y_min_q, y_max_q;
  logic signed [SW-1:0]    x_new, y_new;
  logic [HEADING_W-1:0]    last_heading_q;
  logic [HEADING_W-1:0]    res_heading_q;
  status_e                 res_status_q;
  logic signed [FX_W-1:0]  fx_q;
  logic                    out_valid_q;
  logic [HEADING_W-1:0]    out_heading_q;
  status_e                 out_status_q;

  logic in_fire, out_free, emit, span_zero;
  logic div_start, div_done, cor_start, cor_done, axis_y;

  logic signed [SW-1:0]    lo, hi, v, mid;
  logic signed [SW:0]      sum, sum_adj, diff;
  logic [SW:0]             span, mag;
  logic signed [FX_W-1:0]  quo;
  logic signed [ANG_W-1:0] angle;
  logic [ANG_W-1:0]        angle_mag;
  logic signed [DEG_W-1:0] deg, deg_adj;
  logic [HEADING_W-1:0]    heading;

  assign in_fire   = in_i.valid && in_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign x_new     = in_i.x_sample[SW-1:0];
  assign y_new     = in_i.y_sample[SW-1:0];
  assign span_zero = (x_min_q == x_max_q) || (y_min_q == y_max_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_fire) state_d = in_i.read_ok ? S_CHECK : S_EMIT;
      S_CHECK:  state_d = span_zero ? S_EMIT : S_DIV_X;
      S_DIV_X:  if (div_done) state_d = S_DIV_Y;
      S_DIV_Y:  if (div_done) state_d = S_CORDIC;
      S_CORDIC: if (cor_done) state_d = S_EMIT;
      S_EMIT:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_i.ready = 1'b0;
    div_start  = 1'b0;
    cor_start  = 1'b0;
    axis_y     = 1'b0;
    emit       = 1'b0;
    case (state_q)
      S_IDLE:   in_i.ready = 1'b1;
      S_CHECK:  div_start = !span_zero;
      S_DIV_X: begin
        axis_y    = 1'b1;
        div_start = div_done;
      end
      S_DIV_Y:  cor_start = div_done;
      S_CORDIC: ;
      S_EMIT:   emit = out_free;
      default:  ;
    endcase
  end

  // Centering and span of the selected axis.
  always_comb begin
    lo      = axis_y ? y_min_q : x_min_q;
    hi      = axis_y ? y_max_q : x_max_q;
    v       = axis_y ? y_s_q : x_s_q;
    sum     = {hi[SW-1], hi} + {lo[SW-1], lo};
    sum_adj = sum + {{SW{1'b0}}, sum[SW]};
    mid     = sum_adj[SW:1];
    diff    = {v[SW-1], v} - {mid[SW-1], mid};
    mag     = diff[SW] ? -diff : diff;
    span    = {hi[SW-1], hi} - {lo[SW-1], lo};
  end

  cch_div #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .neg_i   (diff[SW]),
    .mag_i   (mag),
    .den_i   (span),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  cch_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .fx_i    (fx_q),
    .fy_i    (quo),
    .done_o  (cor_done),
    .angle_o (angle)
  );

  // Whole degrees, truncated toward zero, folded into 1..360.
  always_comb begin
    angle_mag = angle[ANG_W-1] ? -angle : angle;
    deg       = DEG_W'(angle_mag[ANG_W-1:FRAC_W]);
    if (angle[ANG_W-1]) deg = -deg;
    deg_adj = deg;
    if (deg <= 0) begin
      deg_adj = deg + DEG_FULL_TURN;
    end else if (deg > DEG_FULL_TURN) begin
      deg_adj = deg - DEG_FULL_TURN;
    end
    heading = deg_adj[HEADING_W-1:0];
  end

  // Sequencer state, calibration bounds, last heading and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      x_min_q        <= '0;
      x_max_q        <= '0;
      y_min_q        <= '0;
      y_max_q        <= '0;
      last_heading_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire && in_i.read_ok) begin
        if (x_new < x_min_q) x_min_q <= x_new;
        if (x_new > x_max_q) x_max_q <= x_new;
        if (y_new < y_min_q) y_min_q <= y_new;
        if (y_new > y_max_q) y_max_q <= y_new;
      end
      if (state_q == S_CORDIC && cor_done) last_heading_q <= heading;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_s_q <= x_new;
      y_s_q <= y_new;
      if (!in_i.read_ok) begin
        res_heading_q <= last_heading_q;
        res_status_q  <= ST_HELD;
      end
    end
    if (state_q == S_CHECK && span_zero) begin
      res_heading_q <= '0;
      res_status_q  <= ST_SPAN_ZERO;
    end
    if (state_q == S_DIV_X && div_done) fx_q <= quo;
    if (state_q == S_CORDIC && cor_done) begin
      res_heading_q <= heading;
      res_status_q  <= ST_NEW;
    end
    if (emit) begin
      out_heading_q <= res_heading_q;
      out_status_q  <= res_status_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.heading_deg = out_heading_q;
  assign out_o.status      = out_status_q;

  // The sequencer takes one request at a time.
  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("request accepted while the previous one is in progress");

  // Bounds stay ordered.
  a_bounds_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (x_min_q <= x_max_q) && (y_min_q <= y_max_q))
    else $error("calibration bounds out of order");

  // A fresh heading lies in 1..360.
  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_NEW) |->
      (out_heading_q != '0) && (out_heading_q <= HEADING_W'(360)))
    else $error("new heading outside 1..360");

  // A zero span reports heading zero.
  a_span_zero_heading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_SPAN_ZERO) |-> (out_heading_q == '0))
    else $error("zero-span result with nonzero heading");

endmodule
